FILE: hw/rtl/scsv_pkg.sv
`default_nettype none

package scsv_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_MODIFY  = 2'd1,
        MODE_DISPLAY = 2'd2
    } mode_t;

    localparam int MILLIS_W  = 10;
    localparam int SECONDS_W = 6;
    localparam int MINUTES_W = 6;
    localparam int HOURS_W   = 5;
    localparam int VALUE_W   = 13;

    localparam logic [MILLIS_W-1:0]  MILLIS_MAX   = 10'd999;
    localparam logic [MILLIS_W-1:0]  COLON_HALF   = 10'd500;
    localparam logic [SECONDS_W-1:0] SECONDS_MAX  = 6'd59;
    localparam logic [MINUTES_W-1:0] MINUTES_MAX  = 6'd59;
    localparam logic [HOURS_W-1:0]   HOURS_MAX    = 5'd23;

    localparam logic [MILLIS_W-1:0]  MILLIS_RST   = 10'd0;
    localparam logic [SECONDS_W-1:0] SECONDS_RST  = 6'd19;
    localparam logic [MINUTES_W-1:0] MINUTES_RST  = 6'd27;
    localparam logic [HOURS_W-1:0]   HOURS_RST    = 5'd13;

endpackage

`default_nettype wire

FILE: hw/rtl/scsv_view.sv
`default_nettype none

module scsv_view
(
    input  wire scsv_pkg::mode_t                  mode_sel,
    input  wire logic [scsv_pkg::HOURS_W-1:0]     hours,
    input  wire logic [scsv_pkg::MINUTES_W-1:0]   minutes,
    input  wire logic [scsv_pkg::SECONDS_W-1:0]   seconds,
    input  wire logic [scsv_pkg::MILLIS_W-1:0]    millis,
    output logic      [scsv_pkg::VALUE_W-1:0]     value
);
    import scsv_pkg::*;

    logic [17:0]        centi_prod;
    logic [6:0]         centis;
    logic [VALUE_W-1:0] hhmm;
    logic [VALUE_W-1:0] sscc;

    // millis / 10 as (millis * 205) >> 11, exact below 1029
    assign centi_prod = {8'd0, millis} * 18'd205;
    assign centis     = centi_prod[17:11];

    assign hhmm = ({8'd0, hours} * 13'd100) + {7'd0, minutes};
    assign sscc = ({7'd0, seconds} * 13'd100) + {6'd0, centis};

    always_comb
    begin
        case (mode_sel)
            MODE_DISPLAY: value = sscc;
            default:      value = hhmm;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/settable_clock_with_stopwatch_view.sv
`default_nettype none

// Time-of-day clock (hh:mm:ss.mmm, reset to 13:27:19.000) with normal, modify and
// display modes. Each item carries button release events, handled first, and an
// optional 1 ms tick. One result item per input item: display_value is hhmm, or
// ss and centiseconds in display mode; colon_on blinks at 1 Hz (normal), 10 Hz
// (display) or holds (modify). The time state and the result register are loaded
// at the same edge, so an item is taken every cycle while the result side keeps
// up; the result appears in the cycle after acceptance and in_ready only drops
// while a result is held back by out_ready.
module settable_clock_with_stopwatch_view
(
    input  wire  logic        clk,
    input  wire  logic        rst_n,
    input  wire  logic        in_valid,
    output logic              in_ready,
    input  wire  logic        tick,
    input  wire  logic        rel_modify,
    input  wire  logic        rel_normal,
    input  wire  logic        rel_hour,
    input  wire  logic        rel_minute,
    output logic              out_valid,
    input  wire  logic        out_ready,
    output logic [12:0]       display_value,
    output logic              colon_on,
    output logic [1:0]        mode
);
    import scsv_pkg::*;

    logic [MILLIS_W-1:0]  millis_reg,  millis_next;
    logic [SECONDS_W-1:0] seconds_reg, seconds_next;
    logic [MINUTES_W-1:0] minutes_reg, minutes_next;
    logic [HOURS_W-1:0]   hours_reg,   hours_next;
    mode_t                mode_reg,    mode_next;
    logic                 colon_reg,   colon_next;
    logic                 out_valid_reg;
    logic [VALUE_W-1:0]   value_reg,   value_next;

    logic                 accept;
    logic [HOURS_W-1:0]   hours_btn;
    logic [MINUTES_W-1:0] minutes_btn;
    logic [MILLIS_W-1:0]  millis_inc;
    logic [16:0]          hund_prod;
    logic [3:0]           hund_q;
    logic [MILLIS_W-1:0]  hund_rem;
    logic                 colon_tick;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign display_value = value_reg;
    assign colon_on  = colon_reg;
    assign mode      = mode_reg;

    // buttons
    always_comb
    begin
        mode_next   = mode_reg;
        hours_btn   = hours_reg;
        minutes_btn = minutes_reg;
        case (mode_reg)
            MODE_MODIFY:
            begin
                if (rel_normal)
                begin
                    mode_next = MODE_NORMAL;
                end
                if (rel_hour)
                begin
                    hours_btn = (hours_reg == HOURS_MAX) ? '0 : hours_reg + 5'd1;
                end
                if (rel_minute)
                begin
                    if (minutes_reg == MINUTES_MAX)
                    begin
                        minutes_btn = '0;
                        hours_btn   = (hours_btn == HOURS_MAX) ? '0 : hours_btn + 5'd1;
                    end
                    else
                    begin
                        minutes_btn = minutes_reg + 6'd1;
                    end
                end
            end
            MODE_NORMAL:
            begin
                if (rel_modify)
                begin
                    mode_next = MODE_MODIFY;
                end
                else if (rel_normal)
                begin
                    mode_next = MODE_DISPLAY;
                end
            end
            MODE_DISPLAY:
            begin
                if (rel_normal)
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // tick
    assign millis_inc = (millis_reg == MILLIS_MAX) ? '0 : millis_reg + 10'd1;
    // millis / 100 as (millis * 41) >> 12, exact below 1000
    assign hund_prod  = {7'd0, millis_inc} * 17'd41;
    assign hund_q     = hund_prod[15:12];
    assign hund_rem   = millis_inc - ({6'd0, hund_q} * 10'd100);

    always_comb
    begin
        case (mode_next)
            MODE_NORMAL:  colon_tick = (millis_inc < COLON_HALF);
            MODE_DISPLAY: colon_tick = (hund_rem < 10'd50);
            default:      colon_tick = colon_reg;
        endcase
    end

    always_comb
    begin
        millis_next  = millis_reg;
        seconds_next = seconds_reg;
        minutes_next = minutes_btn;
        hours_next   = hours_btn;
        colon_next   = colon_reg;
        if (tick)
        begin
            millis_next = millis_inc;
            colon_next  = colon_tick;
            if (millis_reg == MILLIS_MAX)
            begin
                if (seconds_reg == SECONDS_MAX)
                begin
                    seconds_next = '0;
                    if (minutes_btn == MINUTES_MAX)
                    begin
                        minutes_next = '0;
                        hours_next   = (hours_btn == HOURS_MAX) ? '0 : hours_btn + 5'd1;
                    end
                    else
                    begin
                        minutes_next = minutes_btn + 6'd1;
                    end
                end
                else
                begin
                    seconds_next = seconds_reg + 6'd1;
                end
            end
        end
    end

    scsv_view u_view
    (
        .mode_sel (mode_next),
        .hours    (hours_next),
        .minutes  (minutes_next),
        .seconds  (seconds_next),
        .millis   (millis_next),
        .value    (value_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            millis_reg    <= MILLIS_RST;
            seconds_reg   <= SECONDS_RST;
            minutes_reg   <= MINUTES_RST;
            hours_reg     <= HOURS_RST;
            mode_reg      <= MODE_NORMAL;
            colon_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                millis_reg    <= millis_next;
                seconds_reg   <= seconds_next;
                minutes_reg   <= minutes_next;
                hours_reg     <= hours_next;
                mode_reg      <= mode_next;
                colon_reg     <= colon_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= value_next;
        end
    end

endmodule

`default_nettype wire
